// File: rtl/erfe_pkg.sv
// ----------------------------------------------------------------------------
// erfe_pkg
// shared types and constants of the escape-run frame encoder
// ----------------------------------------------------------------------------
package erfe_pkg;

  // longest escape run that is counted, the counter saturates here
  localparam int unsigned MAX_ESCAPE_RUN = 61;

  localparam logic [7:0] ESC_BYTE     = 8'hF0;
  localparam logic [7:0] STANDIN_BYTE = 8'hF1;
  localparam logic [7:0] DELIM_BYTE   = 8'hF2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // operation on the shared run counter
  typedef enum logic [1:0] {
    CTR_HOLD,
    CTR_INC,
    CTR_DEC,
    CTR_CLR
  } ctr_op_e;

  // one byte offered by the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_ESC,
    ST_STANDIN,
    ST_BYTE,
    ST_DELIM
  } state_e;

endpackage

// File: rtl/erfe_run_ctr.sv
// ----------------------------------------------------------------------------
// erfe_run_ctr
// escape run counter with saturating increment, decrement and clear
// ----------------------------------------------------------------------------
module erfe_run_ctr
  import erfe_pkg::*;
#(
  parameter int unsigned MaxEscapeRun = MAX_ESCAPE_RUN,
  parameter int unsigned RunW         = $clog2(MaxEscapeRun + 1)
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ctr_op_e op_i,
  output logic    run_zero_o,
  output logic    run_one_o
);

  logic [RunW-1:0] run_q, run_d;

  always_comb begin
    run_d = run_q;
    unique case (op_i)
      CTR_HOLD: run_d = run_q;
      CTR_INC: begin
        if (run_q < RunW'(MaxEscapeRun)) run_d = run_q + RunW'(1);
      end
      CTR_DEC: run_d = run_q - RunW'(1);
      CTR_CLR: run_d = '0;
      default: run_d = run_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  assign run_zero_o = (run_q == '0);
  assign run_one_o  = (run_q == RunW'(1));

endmodule

// File: rtl/erfe_seq.sv
// ----------------------------------------------------------------------------
// erfe_seq
// sequencer that expands one input byte into its encoded output bytes
// ----------------------------------------------------------------------------
module erfe_seq
  import erfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  in_item_t item_i,
  input  logic     run_zero_i,
  input  logic     run_one_i,
  input  logic     load_ok_i,
  output logic     idle_o,
  output emit_t    emit_o,
  output ctr_op_e  ctr_op_o
);

  state_e     state_q, state_d;
  logic [7:0] data_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      data_q <= item_i.data_byte;
      last_q <= item_i.last_byte;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (item_i.data_byte == DELIM_BYTE || item_i.data_byte == STANDIN_BYTE) begin
            if (!run_zero_i) state_d = ST_RUN;
            else if (item_i.data_byte == DELIM_BYTE) state_d = ST_ESC;
            else state_d = ST_STANDIN;
          end else begin
            state_d = ST_BYTE;
          end
        end
      end
      ST_RUN: begin
        if (load_ok_i && run_one_i) begin
          state_d = (data_q == DELIM_BYTE) ? ST_ESC : ST_STANDIN;
        end
      end
      ST_ESC: begin
        if (load_ok_i) state_d = ST_STANDIN;
      end
      ST_STANDIN, ST_BYTE: begin
        if (load_ok_i) state_d = last_q ? ST_DELIM : ST_IDLE;
      end
      ST_DELIM: begin
        if (load_ok_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit_o   = '{valid: 1'b0, data: '0, last: 1'b0};
    ctr_op_o = CTR_HOLD;
    idle_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: idle_o = 1'b1;
      ST_RUN: begin
        emit_o = '{valid: 1'b1, data: ESC_BYTE, last: 1'b0};
        if (load_ok_i) ctr_op_o = CTR_DEC;
      end
      ST_ESC: emit_o = '{valid: 1'b1, data: ESC_BYTE, last: 1'b0};
      ST_STANDIN: emit_o = '{valid: 1'b1, data: STANDIN_BYTE, last: !last_q};
      ST_BYTE: begin
        emit_o = '{valid: 1'b1, data: data_q, last: !last_q};
        if (load_ok_i) ctr_op_o = (data_q == ESC_BYTE) ? CTR_INC : CTR_CLR;
      end
      ST_DELIM: begin
        emit_o = '{valid: 1'b1, data: DELIM_BYTE, last: 1'b1};
        if (load_ok_i) ctr_op_o = CTR_CLR;
      end
      default: idle_o = 1'b0;
    endcase
  end

endmodule

// File: rtl/escape_run_frame_encoder.sv
// ----------------------------------------------------------------------------
// escape_run_frame_encoder
// escape-run frame encoder, one message byte in, one to 64 frame bytes out
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid_i / in_ready_o carries one message byte and its
//   last-byte flag per transaction; in_ready_o is high only while no byte is
//   being expanded
// - output channel out_valid_o / out_ready_i carries one frame byte per
//   transaction; last_of_run marks the final byte caused by an input byte
// - the input transaction loads the sequencer state register, and the
//   output register then registers the first output byte; the sequencer
//   emits one byte per cycle into the output register while that
//   register can take a byte
// - a stand-in or delimiter byte replays the stored escape run by counting
//   the run counter down, one escape byte per cycle unless stalled
// - when the receiver stalls, the output register holds its byte and the
//   sequencer waits; nothing is dropped
// - reset clears the run counter, the sequencer and the output valid
// ----------------------------------------------------------------------------
module escape_run_frame_encoder
  import erfe_pkg::*;
#(
  parameter int unsigned MaxEscapeRun = MAX_ESCAPE_RUN
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      start;
  logic      load_ok;
  logic      run_zero, run_one;
  emit_t     emit;
  ctr_op_e   ctr_op;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // output register can take a byte when empty or being drained
  assign load_ok = !out_valid_q || out_ready_i;
  assign start   = in_valid_i && in_ready_o;

  erfe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_item_i),
    .run_zero_i (run_zero),
    .run_one_i  (run_one),
    .load_ok_i  (load_ok),
    .idle_o     (in_ready_o),
    .emit_o     (emit),
    .ctr_op_o   (ctr_op)
  );

  // shared counter: counts escapes up, replays them by counting down
  erfe_run_ctr #(
    .MaxEscapeRun (MaxEscapeRun)
  ) u_run_ctr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (ctr_op),
    .run_zero_o (run_zero),
    .run_one_o  (run_one)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_ok) out_valid_d = emit.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_ok && emit.valid) begin
      out_q.out_byte    <= emit.data;
      out_q.last_of_run <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
